### src/rwcl_pkg.sv
// Package for the RIFF/WAVE chunk locator: four-character tags, header sizes
// and result status codes. No dependencies.
package rwcl_pkg;

  localparam logic [31:0] TagRiff = 32'h4646_4952;  // "RIFF" little-endian
  localparam logic [31:0] TagWave = 32'h4556_4157;  // "WAVE"
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;  // "fmt "
  localparam logic [31:0] TagData = 32'h6174_6164;  // "data"

  localparam int unsigned HeaderBytes      = 12;
  localparam int unsigned ChunkHeaderBytes = 8;
  localparam int unsigned FmtMinBytes      = 14;

  // Byte positions inside the 12-byte RIFF header
  localparam logic [31:0] PosRiffTag  = 32'd3;
  localparam logic [31:0] PosRiffLen  = 32'd7;
  localparam logic [31:0] PosWaveTag  = 32'd11;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTooShort  = 3'd1,
    StBadHeader = 3'd2,
    StBadLength = 3'd3,
    StOverrun   = 3'd4,
    StFmtShort  = 3'd5,
    StNotFound  = 3'd6
  } status_e;

endpackage

### src/riff_wave_chunk_locator_unit.sv
// Top level of the RIFF/WAVE chunk locator: byte-wide parser with input and
// result registers. Depends on rwcl_pkg.
//
// Feed the resource one byte per transaction, start_flag_i high on byte 0,
// after writing its total size through cfg_we_i/cfg_wdata_i while idle. The
// unit takes one byte every cycle unless a result waits; each byte sits in the
// input register, where the parser state is updated, and a result lands in the
// output register, so a result is registered after the byte that decides it
// has passed through the input register. While a result waits for out_ready_i,
// the byte in the input register holds and, once that register is full, no
// further byte is taken. At most one result is given per resource: a status
// with the fmt body offset, data body offset and data length recorded so far
// (zero where not recorded). Once a result is given, bytes are dropped until
// the next start flag; a start flag mid-resource restarts parsing.
module riff_wave_chunk_locator_unit
  import rwcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_flag_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] format_offset_o,
  output logic [31:0] data_offset_o,
  output logic [31:0] data_length_o
);

  logic [31:0] res_size_q;

  // input register
  logic        in_vld_q;
  logic        start_q;
  logic [7:0]  byte_q;

  // parser state
  logic [31:0] pos_q, pos_d;
  logic [32:0] riff_end_q, riff_end_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] ctype_q, ctype_d;
  logic [32:0] nhp_q, nhp_d;
  logic        fmt_found_q, fmt_found_d;
  logic [31:0] fmt_pos_q, fmt_pos_d;
  logic        dat_found_q, dat_found_d;
  logic [31:0] dat_pos_q, dat_pos_d;
  logic [31:0] dat_size_q, dat_size_d;
  logic        decided_q, decided_d;

  // result register
  logic        out_vld_q;
  status_e     status_q, status_d;
  logic [31:0] fmt_off_q, dat_off_q, dat_len_q;

  logic        adv;
  logic        fire;
  logic        emit;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || adv;
  assign fire       = in_vld_q && adv;

  always_comb begin
    logic        go;
    logic        stop;
    logic [31:0] p;
    logic [33:0] p_x;
    logic [33:0] body;
    logic [33:0] room;
    logic [33:0] padded;
    logic [33:0] next_pos;
    logic [33:0] rend_x;

    pos_d       = pos_q;
    riff_end_d  = riff_end_q;
    shift_d     = shift_q;
    ctype_d     = ctype_q;
    nhp_d       = nhp_q;
    fmt_found_d = fmt_found_q;
    fmt_pos_d   = fmt_pos_q;
    dat_found_d = dat_found_q;
    dat_pos_d   = dat_pos_q;
    dat_size_d  = dat_size_q;
    decided_d   = decided_q;
    emit        = 1'b0;
    status_d    = StOk;
    go          = 1'b0;
    stop        = 1'b0;
    p           = '0;
    p_x         = '0;
    body        = '0;
    room        = '0;
    padded      = '0;
    next_pos    = '0;
    rend_x      = '0;

    if (fire) begin
      if (start_q) begin
        pos_d       = '0;
        riff_end_d  = '0;
        shift_d     = '0;
        ctype_d     = '0;
        nhp_d       = 33'(HeaderBytes);
        fmt_found_d = 1'b0;
        fmt_pos_d   = '0;
        dat_found_d = 1'b0;
        dat_pos_d   = '0;
        dat_size_d  = '0;
        decided_d   = 1'b0;
        if (res_size_q < 32'(HeaderBytes)) begin
          emit     = 1'b1;
          status_d = StTooShort;
        end else begin
          go = 1'b1;
        end
      end else begin
        go = !decided_q;
      end

      if (go) begin
        shift_d = {byte_q, shift_d[31:8]};
        p       = pos_d;
        pos_d   = p + 32'd1;
        p_x     = {2'b00, p};
        rend_x  = {1'b0, riff_end_d};

        if (p == PosRiffTag) begin
          if (shift_d != TagRiff) begin
            emit     = 1'b1;
            status_d = StBadHeader;
          end
        end else if (p == PosRiffLen) begin
          riff_end_d = {1'b0, shift_d} + 33'(ChunkHeaderBytes);
        end else if (p == PosWaveTag) begin
          if (shift_d != TagWave) begin
            emit     = 1'b1;
            status_d = StBadHeader;
          end else if (riff_end_d < 33'(HeaderBytes) ||
                       riff_end_d > {1'b0, res_size_q}) begin
            emit     = 1'b1;
            status_d = StBadLength;
          end else if ({1'b0, nhp_d} + 34'(ChunkHeaderBytes) > rend_x) begin
            emit     = 1'b1;
            status_d = StNotFound;
          end
        end else if (p >= 32'(HeaderBytes)) begin
          if (p_x == {1'b0, nhp_d} + 34'd3) begin
            ctype_d = shift_d;
          end else if (p_x == {1'b0, nhp_d} + 34'd7) begin
            // last byte of a chunk header: shift_d holds the body length
            body = {1'b0, nhp_d} + 34'(ChunkHeaderBytes);
            room = (rend_x >= body) ? rend_x - body : '0;
            if ({2'b00, shift_d} > room) begin
              emit     = 1'b1;
              status_d = StOverrun;
            end else begin
              if (ctype_d == TagFmt) begin
                if (!fmt_found_d) begin
                  if (shift_d < 32'(FmtMinBytes)) begin
                    emit     = 1'b1;
                    status_d = StFmtShort;
                    stop     = 1'b1;
                  end else begin
                    fmt_found_d = 1'b1;
                    fmt_pos_d   = body[31:0];
                    if (dat_found_d && dat_size_d != '0) begin
                      emit     = 1'b1;
                      status_d = StOk;
                      stop     = 1'b1;
                    end
                  end
                end
              end else if (ctype_d == TagData) begin
                // a zero-length data chunk may be replaced by a later one
                if (!dat_found_d || dat_size_d == '0) begin
                  dat_found_d = 1'b1;
                  dat_pos_d   = body[31:0];
                  dat_size_d  = shift_d;
                  if (fmt_found_d) begin
                    emit     = 1'b1;
                    status_d = StOk;
                    stop     = 1'b1;
                  end
                end
              end

              if (!stop) begin
                // skip the body plus its pad byte when the length is odd
                padded = {2'b00, shift_d} + {33'd0, shift_d[0]};
                if (padded > room) begin
                  emit     = 1'b1;
                  status_d = StOverrun;
                end else begin
                  next_pos = body + padded;
                  nhp_d    = next_pos[32:0];
                  if (next_pos + 34'(ChunkHeaderBytes) > rend_x) begin
                    emit     = 1'b1;
                    status_d = StNotFound;
                  end
                end
              end
            end
          end
        end
      end

      if (emit) begin
        decided_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_size_q  <= '0;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      pos_q       <= '0;
      riff_end_q  <= '0;
      shift_q     <= '0;
      ctype_q     <= '0;
      nhp_q       <= 33'(HeaderBytes);
      fmt_found_q <= 1'b0;
      fmt_pos_q   <= '0;
      dat_found_q <= 1'b0;
      dat_pos_q   <= '0;
      dat_size_q  <= '0;
      decided_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        res_size_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= fire && emit;
      end
      pos_q       <= pos_d;
      riff_end_q  <= riff_end_d;
      shift_q     <= shift_d;
      ctype_q     <= ctype_d;
      nhp_q       <= nhp_d;
      fmt_found_q <= fmt_found_d;
      fmt_pos_q   <= fmt_pos_d;
      dat_found_q <= dat_found_d;
      dat_pos_q   <= dat_pos_d;
      dat_size_q  <= dat_size_d;
      decided_q   <= decided_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      start_q <= start_flag_i;
      byte_q  <= data_byte_i;
    end
    if (fire && emit) begin
      status_q  <= status_d;
      fmt_off_q <= fmt_found_d ? fmt_pos_d : '0;
      dat_off_q <= dat_found_d ? dat_pos_d : '0;
      dat_len_q <= dat_found_d ? dat_size_d : '0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign format_offset_o = fmt_off_q;
  assign data_offset_o   = dat_off_q;
  assign data_length_o   = dat_len_q;

endmodule
